// File: hdl/cfm_pkg.sv
// Shared types and constants for the CPU clock frequency meter.
`timescale 1ns / 1ps
package cfm_pkg;

  localparam int unsigned CNT_W = 64;
  localparam int unsigned FREQ_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_W = 6;
  localparam int unsigned THR_W = 27;

  localparam logic [CFG_IDX_W-1:0] REG_REF_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE = 2'd1;

  localparam logic [FREQ_W-1:0] REF_FREQ_RST = 32'd3579545;
  localparam logic WRAP_MODE_RST = 1'b1;

  localparam logic [FREQ_W-1:0] THR_RECIP = 32'h51EB851F;
  localparam int unsigned THR_SHIFT = 37;

  localparam logic [STEP_W-1:0] MUL_LAST = 6'd31;
  localparam logic [STEP_W-1:0] DIV_LAST = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_CMP,
    ST_CDIFF,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// File: hdl/cpu_clock_frequency_meter_core.sv
// Top level of the CPU clock frequency meter with its sequencer and shared adder.
//
// Usage: each input item is one paired sample of a reference timer count and a
// CPU cycle count. Every accepted item yields exactly one result item with a
// done flag and the frequency in hertz (zero until done).
// The first sample after reset is stored as the start point. Later samples
// form the reference delta, plain or with the PM timer rollover rule, and once
// it reaches ref_freq/100 the frequency is computed and then held until reset.
// Configuration writes (ref_freq at index 0, wrap_mode at index 1) are always
// taken; they are meant to be made while the block is idle.
// Timing: one 64-bit adder serves the delta, compare, difference, multiply and
// divide steps. A first sample or one after completion goes straight to emit;
// a sample below the threshold passes delta and compare first; the completing
// one adds the difference state, 32 shift-add multiply and 64 restoring divide
// steps, one per cycle. The input is stalled while an item is at work.
// Output: the result sits in an output register; while the receiver stalls it
// holds, and the next input item may still be accepted and worked on.
// Reset clears the start point and the done flag and restores the configuration.
`timescale 1ns / 1ps
module cpu_clock_frequency_meter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cfm_pkg::CNT_W-1:0]         in_ref_count,
  input  logic [cfm_pkg::CNT_W-1:0]         in_cycle_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_done_res,
  output logic [cfm_pkg::CNT_W-1:0]         out_frequency,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfm_pkg::FREQ_W-1:0]        cfg_data
);
  import cfm_pkg::*;

  state_t state_r, state_nxt;

  logic              started_r, started_nxt;
  logic              finished_r, finished_nxt;
  logic [CNT_W-1:0]  start_ref_r, start_ref_nxt;
  logic [CNT_W-1:0]  start_cyc_r, start_cyc_nxt;
  logic [CNT_W-1:0]  held_freq_r, held_freq_nxt;
  logic [FREQ_W-1:0] ref_freq_r, ref_freq_nxt;
  logic              wrap_mode_r, wrap_mode_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic [CNT_W-1:0]  cc_r, cc_nxt;
  logic [CNT_W-1:0]  delta_r, delta_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  mcand_r, mcand_nxt;
  logic [FREQ_W-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              res_done_r, res_done_nxt;
  logic [CNT_W-1:0]  res_freq_r, res_freq_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_done_r, out_done_nxt;
  logic [CNT_W-1:0]  out_freq_r, out_freq_nxt;

  logic [CNT_W-1:0]  alu_a;
  logic [CNT_W-1:0]  alu_b;
  logic              alu_sub;
  logic [CNT_W:0]    alu_sum;
  logic [CNT_W-1:0]  alu_res;
  logic              alu_carry;

  logic [2*FREQ_W-1:0] thr_prod;
  logic [THR_W-1:0]    thr_eff;
  logic [CNT_W-1:0]    acc_upd;
  logic [CNT_W:0]      rem_sh;
  logic                div_ge;

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {{CNT_W{1'b0}}, alu_sub};
  assign alu_res = alu_sum[CNT_W-1:0];
  assign alu_carry = alu_sum[CNT_W];

  assign thr_prod = {{FREQ_W{1'b0}}, ref_freq_r} * {{FREQ_W{1'b0}}, THR_RECIP};
  assign thr_eff = (thr_r == '0) ? {{(THR_W-1){1'b0}}, 1'b1} : thr_r;
  assign rem_sh = {rem_r, quo_r[CNT_W-1]};
  assign acc_upd = mplier_r[0] ? alu_res : acc_r;
  assign div_ge = rem_sh[CNT_W] | alu_carry;

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_done_res = out_done_r;
  assign out_frequency = out_freq_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      started_r <= 1'b0;
      finished_r <= 1'b0;
      ref_freq_r <= REF_FREQ_RST;
      wrap_mode_r <= WRAP_MODE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      started_r <= started_nxt;
      finished_r <= finished_nxt;
      ref_freq_r <= ref_freq_nxt;
      wrap_mode_r <= wrap_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_ref_r <= start_ref_nxt;
    start_cyc_r <= start_cyc_nxt;
    held_freq_r <= held_freq_nxt;
    rc_r <= rc_nxt;
    cc_r <= cc_nxt;
    delta_r <= delta_nxt;
    thr_r <= thr_nxt;
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    res_done_r <= res_done_nxt;
    res_freq_r <= res_freq_nxt;
    out_done_r <= out_done_nxt;
    out_freq_r <= out_freq_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    started_nxt = started_r;
    finished_nxt = finished_r;
    start_ref_nxt = start_ref_r;
    start_cyc_nxt = start_cyc_r;
    held_freq_nxt = held_freq_r;
    ref_freq_nxt = ref_freq_r;
    wrap_mode_nxt = wrap_mode_r;
    rc_nxt = rc_r;
    cc_nxt = cc_r;
    delta_nxt = delta_r;
    thr_nxt = thr_r;
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    res_done_nxt = res_done_r;
    res_freq_nxt = res_freq_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_done_nxt = out_done_r;
    out_freq_nxt = out_freq_r;
    alu_a = rem_sh[CNT_W-1:0];
    alu_b = delta_r;
    alu_sub = 1'b1;

    if (cfg_valid) begin
      case (cfg_index)
        REG_REF_FREQ: ref_freq_nxt = cfg_data;
        REG_WRAP_MODE: wrap_mode_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rc_nxt = in_ref_count;
          cc_nxt = in_cycle_count;
          if (finished_r) begin
            res_done_nxt = 1'b1;
            res_freq_nxt = held_freq_r;
            state_nxt = ST_EMIT;
          end else if (!started_r) begin
            started_nxt = 1'b1;
            start_ref_nxt = in_ref_count;
            start_cyc_nxt = in_cycle_count;
            res_done_nxt = 1'b0;
            res_freq_nxt = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_DELTA;
          end
        end
      end
      ST_DELTA: begin
        thr_nxt = thr_prod[THR_SHIFT +: THR_W];
        if (wrap_mode_r) begin
          alu_a = {32'b0, rc_r[31:0]};
          alu_b = {32'b0, start_ref_r[31:0]};
        end else begin
          alu_a = rc_r;
          alu_b = start_ref_r;
        end
        if (wrap_mode_r && !alu_carry) begin
          if ((&alu_res[CNT_W-1:24]) && (|alu_res[23:0])) begin
            delta_nxt = {40'b0, alu_res[23:0]};
          end else begin
            delta_nxt = {32'b0, alu_res[31:0]};
          end
        end else begin
          delta_nxt = alu_res;
        end
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        alu_a = delta_r;
        alu_b = {{(CNT_W-THR_W){1'b0}}, thr_eff};
        if (alu_carry) begin
          state_nxt = ST_CDIFF;
        end else begin
          res_done_nxt = 1'b0;
          res_freq_nxt = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_CDIFF: begin
        alu_a = cc_r;
        alu_b = start_cyc_r;
        mcand_nxt = alu_res;
        acc_nxt = '0;
        mplier_nxt = ref_freq_r;
        cnt_nxt = MUL_LAST;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        alu_a = acc_r;
        alu_b = mcand_r;
        alu_sub = 1'b0;
        acc_nxt = acc_upd;
        mcand_nxt = {mcand_r[CNT_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[FREQ_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          quo_nxt = acc_upd;
          rem_nxt = '0;
          cnt_nxt = DIV_LAST;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? alu_res : rem_sh[CNT_W-1:0];
        quo_nxt = {quo_r[CNT_W-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          finished_nxt = 1'b1;
          held_freq_nxt = {quo_r[CNT_W-2:0], div_ge};
          res_done_nxt = 1'b1;
          res_freq_nxt = {quo_r[CNT_W-2:0], div_ge};
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_done_nxt = res_done_r;
          out_freq_nxt = res_freq_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/cfm_checker.sv
// Port-level assertions for the CPU clock frequency meter and their bind.
`timescale 1ns / 1ps
module cfm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_done_res,
  input logic [cfm_pkg::CNT_W-1:0] out_frequency
);
  import cfm_pkg::*;

  logic             seen_done_r;
  logic [CNT_W-1:0] seen_freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_done_r <= 1'b0;
    end else if (out_valid && !out_stall && out_done_res) begin
      seen_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall && out_done_res) begin
      seen_freq_r <= out_frequency;
    end
  end

  a_not_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_frequency == '0)
    else $error("Result without done carries a nonzero frequency.");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_done_r |-> out_done_res && out_frequency == seen_freq_r)
    else $error("Held frequency changed or done dropped after completion.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input not stalled while an item is at work.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frequency) && $stable(out_done_res))
    else $error("Stalled result changed or was dropped.");

endmodule

bind cpu_clock_frequency_meter_core cfm_checker u_cfm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_done_res(out_done_res),
  .out_frequency(out_frequency)
);
